[design/sha256_pkg.sv]
`default_nettype none

package sha256_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_MARK,
        S_ZERO,
        S_LEN,
        S_OUT
    } t_state;

    typedef logic [31:0] t_word;

    localparam int unsigned NUM_ROUNDS  = 64;
    localparam int unsigned WINDOW_LEN  = 16;
    localparam int unsigned CHAIN_LEN   = 8;
    localparam logic [6:0]  BLOCK_BYTES = 7'd64;
    localparam logic [6:0]  LEN_OFFSET  = 7'd56;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    localparam t_word ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word INITIAL_CHAIN [CHAIN_LEN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word big_sigma0(input t_word x);
        return ((x >> 2) | (x << 30)) ^ ((x >> 13) | (x << 19)) ^ ((x >> 22) | (x << 10));
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return ((x >> 6) | (x << 26)) ^ ((x >> 11) | (x << 21)) ^ ((x >> 25) | (x << 7));
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return ((x >> 7) | (x << 25)) ^ ((x >> 18) | (x << 14)) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return ((x >> 17) | (x << 15)) ^ ((x >> 19) | (x << 13)) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

[design/sha256_stream_hasher.sv]
// SHA-256 hasher for a byte stream.
// The slave channel carries one transaction per message byte: tdata holds the
// byte, tuser says whether the byte is present, and tlast closes the message.
// A transaction with tuser low and tlast high closes a message without a byte.
// A byte that neither fills the 64-byte block nor closes the message leaves
// tready high. The byte that completes a block starts a compression of 64
// rounds, one round per cycle in a single round unit, followed by a chain
// update, and tready stays low meanwhile.
// Closing a message writes the 0x80 mark, then the zero bytes one per cycle up
// to the length field, then the length, and compresses.
// The digest leaves on the master channel as four 64-bit big-endian words,
// most significant first, with the word index in tuser and tlast on the fourth.
// When the receiver stalls, the current word holds and no new input is taken.
// After the fourth word the initial chain value is reloaded for the next message.
// A synchronous reset restores the initial chain value and empties the buffer.
`default_nettype none

module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,  // data_byte
    input  wire         s_axis_tuser,  // byte_valid
    input  wire         s_axis_tlast,  // last_byte
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,  // digest_word
    output logic [1:0]  m_axis_tuser,  // word_index
    output logic        m_axis_tlast   // last_word
);

    t_state      r_state;
    t_state      n_state;
    t_word       r_chain [CHAIN_LEN];
    t_word       r_wv [CHAIN_LEN];
    t_word       r_win [WINDOW_LEN];
    logic [6:0]  r_fill;
    logic [63:0] r_bits;
    logic [5:0]  r_round;
    logic [1:0]  r_widx;
    logic        r_close;
    logic        r_mark_done;
    logic        r_len_done;

    logic        s_accept;
    logic        m_accept;
    logic        start_comp;
    t_word       sched_w;
    t_word       w;
    t_word       t1;
    t_word       t2;

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign m_accept   = m_axis_tvalid && m_axis_tready;
    assign start_comp = (n_state == S_ROUND) && (r_state != S_ROUND);

    assign sched_w = small_sigma1(r_win[14]) + r_win[9] + small_sigma0(r_win[1]) + r_win[0];
    assign w       = r_round[5:4] == 2'b00 ? r_win[0] : sched_w;
    assign t1      = r_wv[7] + big_sigma1(r_wv[4])
                   + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
                   + ROUND_K[r_round] + w;
    assign t2      = big_sigma0(r_wv[0])
                   + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tuser && (r_fill == BLOCK_BYTES - 7'd1)) begin
                        n_state = S_ROUND;
                    end else if (s_axis_tlast) begin
                        n_state = S_MARK;
                    end
                end
            end
            S_ROUND: begin
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_len_done) begin
                    n_state = S_OUT;
                end else if (r_close) begin
                    n_state = r_mark_done ? S_ZERO : S_MARK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MARK: begin
                n_state = S_ZERO;
            end
            S_ZERO: begin
                if (r_fill == LEN_OFFSET) begin
                    n_state = S_LEN;
                end else if (r_fill == BLOCK_BYTES) begin
                    n_state = S_ROUND;
                end
            end
            S_LEN: begin
                n_state = S_ROUND;
            end
            S_OUT: begin
                if (m_accept && (r_widx == 2'd3)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
        m_axis_tdata  = {r_chain[{r_widx, 1'b0}], r_chain[{r_widx, 1'b1}]};
        m_axis_tuser  = r_widx;
        m_axis_tlast  = (r_widx == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_bits      <= '0;
            r_round     <= '0;
            r_widx      <= '0;
            r_close     <= 1'b0;
            r_mark_done <= 1'b0;
            r_len_done  <= 1'b0;
            for (int i = 0; i < CHAIN_LEN; i++) begin
                r_chain[i] <= INITIAL_CHAIN[i];
            end
        end else begin
            r_state <= n_state;
            if (start_comp) begin
                r_round <= '0;
                for (int i = 0; i < CHAIN_LEN; i++) begin
                    r_wv[i] <= r_chain[i];
                end
                if (r_fill == BLOCK_BYTES || (r_state == S_IDLE)) begin
                    r_fill <= '0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_close <= s_axis_tlast;
                        if (s_axis_tuser) begin
                            r_win[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= s_axis_tdata;
                            r_bits <= r_bits + 64'd8;
                            if (!start_comp) begin
                                r_fill <= r_fill + 7'd1;
                            end
                        end
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                        r_win[i] <= r_win[i + 1];
                    end
                    r_win[WINDOW_LEN - 1] <= w;
                    r_wv[7] <= r_wv[6];
                    r_wv[6] <= r_wv[5];
                    r_wv[5] <= r_wv[4];
                    r_wv[4] <= r_wv[3] + t1;
                    r_wv[3] <= r_wv[2];
                    r_wv[2] <= r_wv[1];
                    r_wv[1] <= r_wv[0];
                    r_wv[0] <= t1 + t2;
                end
                S_ADD: begin
                    for (int i = 0; i < CHAIN_LEN; i++) begin
                        r_chain[i] <= r_chain[i] + r_wv[i];
                    end
                end
                S_MARK: begin
                    r_win[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= PAD_MARK;
                    r_fill      <= r_fill + 7'd1;
                    r_mark_done <= 1'b1;
                end
                S_ZERO: begin
                    if (r_fill != LEN_OFFSET && r_fill != BLOCK_BYTES) begin
                        r_win[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= 8'h00;
                        r_fill <= r_fill + 7'd1;
                    end
                end
                S_LEN: begin
                    r_win[WINDOW_LEN - 2] <= r_bits[63:32];
                    r_win[WINDOW_LEN - 1] <= r_bits[31:0];
                    r_len_done <= 1'b1;
                end
                S_OUT: begin
                    if (m_accept) begin
                        r_widx <= r_widx + 2'd1;
                        if (r_widx == 2'd3) begin
                            for (int i = 0; i < CHAIN_LEN; i++) begin
                                r_chain[i] <= INITIAL_CHAIN[i];
                            end
                            r_fill      <= '0;
                            r_bits      <= '0;
                            r_close     <= 1'b0;
                            r_mark_done <= 1'b0;
                            r_len_done  <= 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
